// ===== rtl/core/bfka_pkg.sv =====
// ----------------------------------------------------------------------------
// Best-fit keyed block allocator package
// Shared sizes, operation and status codes, sequencer states and the structs
// that pass between the directory, the scan unit and the sequencer.
// ----------------------------------------------------------------------------
package bfka_pkg;

    localparam int BLOCK_COUNT = 32;
    localparam int IDX_W       = $clog2(BLOCK_COUNT);
    localparam int CNT_W       = $clog2(BLOCK_COUNT + 1);

    localparam int OP_W        = 3;
    localparam int KEY_W       = 40;
    localparam int SIZE_W      = 8;
    localparam int SLOT_W      = 5;
    localparam int CAP_W       = 8;
    localparam int STATUS_W    = 2;
    localparam int FREED_W     = 6;

    localparam int S_TDATA_W   = 64;
    localparam int S_TUSER_W   = OP_W;
    localparam int M_TDATA_W   = 24;
    localparam int M_TUSER_W   = STATUS_W;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 3'd0,
        OP_GET     = 3'd1,
        OP_DELETE  = 3'd2,
        OP_SWEEP   = 3'd3,
        OP_SET_CAP = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_NO_FIT    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic              valid;
        logic              active;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
        logic [CAP_W-1:0]  cap;
    } dir_rd_t;

    typedef struct packed {
        logic              valid_we;
        logic              valid_val;
        logic              active_we;
        logic              active_val;
        logic              data_we;
        logic              cap_we;
        logic [IDX_W-1:0]  idx;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
        logic [CAP_W-1:0]  cap;
    } dir_wr_t;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [SIZE_W-1:0] hit_size;
        logic              best;
        logic [IDX_W-1:0]  best_idx;
        logic [CNT_W-1:0]  freed;
    } scan_res_t;

endpackage

// ===== rtl/core/best_fit_keyed_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Best-fit keyed block allocator core
// Each item is one operation on a directory of blocks: insert, get, delete,
// sweep of inactive blocks or capacity load. Every item yields one result.
// ----------------------------------------------------------------------------
// Insert, get, delete and sweep are accepted, then the scan unit walks all
// 32 directory entries, and the result is committed into the output
// register. Capacity loads and unused operation codes skip the walk. The
// input is not ready while an item is in progress; a finished result may
// wait in the output register while the next item is accepted.
module best_fit_keyed_block_allocator_core
    import bfka_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // item_key, item_size, target_slot, block_capacity, zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // operation
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // result_slot, stored_size, freed_count, zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // status
    output logic [M_TUSER_W-1:0] m_tuser
);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [OP_W-1:0]   op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [SLOT_W-1:0] target_reg;
    logic [CAP_W-1:0]  cap_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    logic      accept;
    logic      scan_step;
    logic      scan_last;
    logic      commit_fire;
    logic      needs_scan;
    dir_rd_t   entry;
    dir_wr_t   wr;
    scan_res_t res;

    status_t            out_status;
    logic [SLOT_W-1:0]  out_slot;
    logic [SIZE_W-1:0]  out_size;
    logic [FREED_W-1:0] out_freed;

    assign accept     = s_tvalid && s_tready;
    assign scan_last  = (idx_reg == IDX_W'(BLOCK_COUNT - 1));
    assign needs_scan = (s_tuser == OP_INSERT) || (s_tuser == OP_GET) ||
                        (s_tuser == OP_DELETE) || (s_tuser == OP_SWEEP);

    bfka_dir u_dir (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_idx  (idx_reg),
        .rd      (entry),
        .wr      (wr)
    );

    bfka_unit u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .step    (scan_step),
        .op      (op_reg),
        .key     (key_reg),
        .size    (size_reg),
        .idx     (idx_reg),
        .entry   (entry),
        .res     (res)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = needs_scan ? S_SCAN : S_COMMIT;
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = (state_reg == S_IDLE);
        scan_step   = (state_reg == S_SCAN);
        commit_fire = (state_reg == S_COMMIT) && (!m_tvalid_reg || m_tready);

        wr            = '0;
        wr.idx        = idx_reg;
        wr.key        = key_reg;
        wr.size       = size_reg;
        wr.cap        = cap_reg;
        out_status    = ST_OK;
        out_slot      = '0;
        out_size      = '0;
        out_freed     = '0;

        if (scan_step && op_reg == OP_SWEEP) begin
            wr.valid_we   = entry.valid && !entry.active;
            wr.valid_val  = 1'b0;
            wr.active_we  = 1'b1;
            wr.active_val = 1'b0;
        end

        if (commit_fire) begin
            unique case (op_reg)
                OP_INSERT: begin
                    if (res.hit) begin
                        out_status = ST_DUPLICATE;
                    end else if (!res.best) begin
                        out_status = ST_NO_FIT;
                    end else begin
                        wr.idx        = res.best_idx;
                        wr.data_we    = 1'b1;
                        wr.valid_we   = 1'b1;
                        wr.valid_val  = 1'b1;
                        wr.active_we  = 1'b1;
                        wr.active_val = 1'b1;
                        out_slot      = SLOT_W'(res.best_idx);
                        out_size      = size_reg;
                    end
                end
                OP_GET, OP_DELETE: begin
                    if (!res.hit) begin
                        out_status = ST_NOT_FOUND;
                    end else begin
                        wr.idx       = res.hit_idx;
                        wr.active_we = 1'b1;
                        if (op_reg == OP_GET) begin
                            wr.active_val = 1'b1;
                        end else begin
                            wr.active_val = 1'b0;
                            wr.valid_we   = 1'b1;
                            wr.valid_val  = 1'b0;
                        end
                        out_slot = SLOT_W'(res.hit_idx);
                        out_size = res.hit_size;
                    end
                end
                OP_SWEEP: begin
                    out_freed = FREED_W'(res.freed);
                end
                OP_SET_CAP: begin
                    wr.idx    = IDX_W'(target_reg);
                    wr.cap_we = (32'(target_reg) < BLOCK_COUNT);
                end
                default: begin
                    out_status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            idx_reg    <= '0;
            op_reg     <= s_tuser;
            key_reg    <= s_tdata[39:0];
            size_reg   <= s_tdata[47:40];
            target_reg <= s_tdata[52:48];
            cap_reg    <= s_tdata[60:53];
        end else if (scan_step && !scan_last) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
        if (commit_fire) begin
            m_tdata_reg <= {5'b0, out_freed, out_size, out_slot};
            m_tuser_reg <= out_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/core/bfka_dir.sv =====
// ----------------------------------------------------------------------------
// Block directory
// Holds key, size, capacity, valid and active mark of every block, with one
// read port at the scan index and one write port driven by the sequencer.
// ----------------------------------------------------------------------------
module bfka_dir
    import bfka_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] rd_idx,
    output dir_rd_t          rd,
    input  dir_wr_t          wr
);

    logic [KEY_W-1:0]       key_mem  [BLOCK_COUNT];
    logic [SIZE_W-1:0]      size_mem [BLOCK_COUNT];
    logic [CAP_W-1:0]       cap_reg  [BLOCK_COUNT];
    logic [BLOCK_COUNT-1:0] valid_reg;
    logic [BLOCK_COUNT-1:0] active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            active_reg <= '0;
            for (int i = 0; i < BLOCK_COUNT; i++) begin
                cap_reg[i] <= '0;
            end
        end else begin
            if (wr.valid_we) begin
                valid_reg[wr.idx] <= wr.valid_val;
            end
            if (wr.active_we) begin
                active_reg[wr.idx] <= wr.active_val;
            end
            if (wr.cap_we) begin
                cap_reg[wr.idx] <= wr.cap;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.data_we) begin
            key_mem[wr.idx]  <= wr.key;
            size_mem[wr.idx] <= wr.size;
        end
    end

    always_comb begin
        rd.valid  = valid_reg[rd_idx];
        rd.active = active_reg[rd_idx];
        rd.key    = key_mem[rd_idx];
        rd.size   = size_mem[rd_idx];
        rd.cap    = cap_reg[rd_idx];
    end

endmodule

// ===== rtl/core/bfka_unit.sv =====
// ----------------------------------------------------------------------------
// Scan unit
// Looks at one directory entry per cycle and keeps the running results: the
// first block holding the key, the best fitting free block and the number
// of blocks a sweep frees.
// ----------------------------------------------------------------------------
module bfka_unit
    import bfka_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              step,
    input  logic [OP_W-1:0]   op,
    input  logic [KEY_W-1:0]  key,
    input  logic [SIZE_W-1:0] size,
    input  logic [IDX_W-1:0]  idx,
    input  dir_rd_t           entry,
    output scan_res_t         res
);

    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [SIZE_W-1:0] hit_size_reg, hit_size_next;
    logic              best_reg, best_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [CAP_W-1:0]  best_cap_reg, best_cap_next;
    logic [CNT_W-1:0]  freed_reg, freed_next;
    logic              match;
    logic              fit;

    assign match = entry.valid && (entry.key == key);
    assign fit   = !entry.valid && (entry.cap >= size) &&
                   (!best_reg || (entry.cap < best_cap_reg));

    always_comb begin
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_size_next = hit_size_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        best_cap_next = best_cap_reg;
        freed_next    = freed_reg;
        if (start) begin
            hit_next   = 1'b0;
            best_next  = 1'b0;
            freed_next = '0;
        end else if (step) begin
            if (match && !hit_reg) begin
                hit_next      = 1'b1;
                hit_idx_next  = idx;
                hit_size_next = entry.size;
            end
            if (fit) begin
                best_next     = 1'b1;
                best_idx_next = idx;
                best_cap_next = entry.cap;
            end
            if (op == OP_SWEEP && entry.valid && !entry.active) begin
                freed_next = freed_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg   <= 1'b0;
            best_reg  <= 1'b0;
            freed_reg <= '0;
        end else begin
            hit_reg   <= hit_next;
            best_reg  <= best_next;
            freed_reg <= freed_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_idx_reg  <= hit_idx_next;
        hit_size_reg <= hit_size_next;
        best_idx_reg <= best_idx_next;
        best_cap_reg <= best_cap_next;
    end

    always_comb begin
        res.hit      = hit_reg;
        res.hit_idx  = hit_idx_reg;
        res.hit_size = hit_size_reg;
        res.best     = best_reg;
        res.best_idx = best_idx_reg;
        res.freed    = freed_reg;
    end

endmodule

// ===== rtl/core/bfka_checker.sv =====
// ----------------------------------------------------------------------------
// Best-fit keyed block allocator port checker
// Watches the ports of the core and flags results or handshakes that the
// allocator can never produce.
// ----------------------------------------------------------------------------
module bfka_checker
    import bfka_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Input ready straight after an accepted item.");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled result item changed.");

    a_failure_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_DUPLICATE || m_tuser == ST_NO_FIT ||
                     m_tuser == ST_NOT_FOUND) |-> m_tdata == '0)
        else $error("Failed operation returned non-zero fields.");

    a_freed_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[18:13] != 6'd0 |->
            m_tuser == ST_OK && m_tdata[12:0] == 13'd0)
        else $error("Sweep result carried slot or size.");

    a_freed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[18:13]) <= BLOCK_COUNT)
        else $error("Freed count exceeds the directory size.");

endmodule

bind best_fit_keyed_block_allocator_core bfka_checker u_bfka_checker (.*);
